/* sv/tpc_pkg.sv */
package tpc_pkg;

  // Fixed-point scaling of the controller output range.
  localparam int ONE_Q24_SHIFT = 24;
  localparam int FULL_SCALE = 255;
  localparam int PEDAL_LOW = 18;
  localparam int PEDAL_SPAN = 84;

  // Default output limits.
  localparam int OUT_MIN_DEF = 0;
  localparam int OUT_MAX_DEF = 255;

  // Configuration register indexes.
  localparam logic [2:0] REG_TPS_MIN   = 3'd0;
  localparam logic [2:0] REG_TPS_MAX   = 3'd1;
  localparam logic [2:0] REG_KP        = 3'd2;
  localparam logic [2:0] REG_KI        = 3'd3;
  localparam logic [2:0] REG_KD        = 3'd4;
  localparam logic [2:0] REG_REVERSE   = 3'd5;
  localparam logic [2:0] REG_PROP_MEAS = 3'd6;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic signed [8:0]  num_tps;   // tps_sample - tps_min
    logic signed [8:0]  den_tps;   // tps_max - tps_min
    logic signed [10:0] target;
    logic               cal_err;
  } tpc_job_t;

endpackage

/* sv/tpc_front.sv */
module tpc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        tps_sample,
  input  logic [7:0]        pedal_sample,
  input  logic [7:0]        tps_min,
  input  logic [7:0]        tps_max,
  output logic              job_valid,
  input  logic              job_take,
  output tpc_pkg::tpc_job_t job
);
  import tpc_pkg::*;

  // Reciprocal of the pedal span, exact for every 16-bit magnitude that can occur.
  localparam int PEDAL_RECIP_SHIFT = 24;
  localparam logic [33:0] PEDAL_RECIP =
    34'(((1 << PEDAL_RECIP_SHIFT) + PEDAL_SPAN - 1) / PEDAL_SPAN);

  // Two-entry queue between front and back.
  tpc_job_t   q [2];
  logic [1:0] count;
  logic       wptr;
  logic       rptr;
  tpc_job_t   fresh;
  logic       ped_neg;
  logic [7:0] ped_mag;
  logic [15:0] ped_num;
  logic [33:0] ped_recip;
  logic [10:0] ped_q;
  logic       push;
  logic       pop;

  // Pedal target: scale the magnitude, divide by reciprocal multiplication, restore the
  // sign so the quotient truncates toward zero.
  always_comb begin
    ped_neg   = pedal_sample < 8'(PEDAL_LOW);
    ped_mag   = ped_neg ? 8'(PEDAL_LOW) - pedal_sample : pedal_sample - 8'(PEDAL_LOW);
    ped_num   = 16'(ped_mag) * 16'(FULL_SCALE);
    ped_recip = 34'(ped_num) * PEDAL_RECIP;
    ped_q     = 11'(ped_recip >> PEDAL_RECIP_SHIFT);
    fresh.num_tps = signed'({1'b0, tps_sample}) - signed'({1'b0, tps_min});
    fresh.den_tps = signed'({1'b0, tps_max}) - signed'({1'b0, tps_min});
    fresh.target  = ped_neg ? -ped_q : ped_q;
    fresh.cal_err = (tps_max == tps_min);
  end

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign job_valid = (count != 2'd0);
  assign pop       = job_valid && job_take;
  assign job       = q[rptr];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= fresh;
    end
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* sv/tpc_back.sv */
module tpc_back #(
  parameter int OUT_MIN = tpc_pkg::OUT_MIN_DEF,
  parameter int OUT_MAX = tpc_pkg::OUT_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_take,
  input  tpc_pkg::tpc_job_t job,
  input  logic [31:0]       kp_gain,
  input  logic [31:0]       ki_gain,
  input  logic [31:0]       kd_gain,
  input  logic              reverse_direction,
  input  logic              prop_on_measurement,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        drive_value,
  output logic [16:0]       throttle_position,
  output logic [10:0]       target_position,
  output logic              calibration_error
);
  import tpc_pkg::*;

  localparam logic signed [51:0] LO_Q = 52'(OUT_MIN) <<< ONE_Q24_SHIFT;
  localparam logic signed [51:0] HI_Q = 52'(OUT_MAX) <<< ONE_Q24_SHIFT;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MUL, S_INT, S_OUT, S_HOLD
  } state_t;

  state_t state;
  logic [4:0]  bit_cnt;
  logic [16:0] rem;
  logic [16:0] quo;
  logic [16:0] dvd;
  logic [8:0]  dvs;
  logic        neg_q;
  logic signed [17:0] position;
  logic signed [17:0] prev_pos;
  logic        primed;
  logic signed [10:0] target;
  logic        cal_err;
  logic signed [39:0] integ;
  logic [1:0]  mul_sel;
  logic signed [51:0] p_kp_e, p_ki_e, p_kp_d, p_kd_d;
  logic signed [51:0] acc_int;
  logic signed [51:0] acc_out;
  logic signed [51:0] int_clamped;
  logic signed [51:0] out_clamped;
  logic signed [18:0] err_v, dpos_v, mul_b;
  logic signed [32:0] mul_a;
  logic signed [51:0] mul_p;
  logic [16:0] rem_try;
  logic [16:0] rem_sh;

  // Error and derivative operands.
  always_comb begin
    err_v  = 19'(target) - 19'(position);
    dpos_v = 19'(position) - 19'(prev_pos);
  end

  // One shared multiplier, operand chosen by step.
  always_comb begin
    unique case (mul_sel)
      2'd0: begin mul_a = 33'(signed'(kp_gain)); mul_b = err_v; end
      2'd1: begin mul_a = 33'(signed'(ki_gain)); mul_b = err_v; end
      2'd2: begin mul_a = 33'(signed'(kp_gain)); mul_b = dpos_v; end
      default: begin mul_a = 33'(signed'(kd_gain)); mul_b = dpos_v; end
    endcase
    if (reverse_direction) mul_a = -mul_a;
    mul_p = 52'(mul_a * 52'(mul_b));
  end

  // Restoring divider step.
  always_comb begin
    rem_sh  = {rem[15:0], dvd[16]};
    rem_try = rem_sh - 17'(dvs);
  end

  // Integral and output clamping.
  always_comb begin
    acc_int = 52'(integ) + p_ki_e - (prop_on_measurement ? p_kp_d : 52'sd0);
    if (acc_int > HI_Q) int_clamped = HI_Q;
    else if (acc_int < LO_Q) int_clamped = LO_Q;
    else int_clamped = acc_int;
    acc_out = (prop_on_measurement ? 52'sd0 : p_kp_e) + 52'(integ) - p_kd_d;
    if (acc_out > HI_Q) out_clamped = HI_Q;
    else if (acc_out < LO_Q) out_clamped = LO_Q;
    else out_clamped = acc_out;
  end

  assign job_take  = (state == S_IDLE) && job_valid;
  assign out_valid = (state == S_HOLD);

  // Sequencer: divide 17 steps, four multiplies, integrate, output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      integ    <= '0;
      prev_pos <= '0;
      primed   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            target  <= job.target;
            cal_err <= job.cal_err;
            dvd     <= 17'(job.num_tps[8] ? -job.num_tps : job.num_tps) * 17'(FULL_SCALE);
            dvs     <= job.den_tps[8] ? 9'(-job.den_tps) : 9'(job.den_tps);
            neg_q   <= job.num_tps[8] ^ job.den_tps[8];
            rem     <= '0;
            quo     <= '0;
            bit_cnt <= 5'd0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          dvd <= {dvd[15:0], 1'b0};
          if (rem_try[16] == 1'b0) begin
            rem <= rem_try;
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[15:0], 1'b0};
          end
          if (bit_cnt == 5'd16) begin
            state   <= S_MUL;
            mul_sel <= 2'd0;
          end
          bit_cnt <= bit_cnt + 5'd1;
        end
        S_MUL: begin
          if (mul_sel == 2'd0) begin
            // Quotient is ready; fix sign and prime the history.
            if (cal_err) position <= '0;
            else position <= neg_q ? -18'(quo) : 18'(quo);
            if (!primed) begin
              prev_pos <= cal_err ? 18'sd0 : (neg_q ? -18'(quo) : 18'(quo));
              primed   <= 1'b1;
            end
            mul_sel <= 2'd0;
            state   <= S_INT;
          end
        end
        S_INT: begin
          unique case (mul_sel)
            2'd0: p_kp_e <= mul_p;
            2'd1: p_ki_e <= mul_p;
            2'd2: p_kp_d <= mul_p;
            default: p_kd_d <= mul_p;
          endcase
          mul_sel <= mul_sel + 2'd1;
          if (mul_sel == 2'd3) state <= S_OUT;
        end
        S_OUT: begin
          if (bit_cnt[0]) begin
            integ <= int_clamped[39:0];
            bit_cnt <= 5'd0;
          end else begin
            drive_value       <= 8'(out_clamped >>> ONE_Q24_SHIFT);
            throttle_position <= position[16:0];
            target_position   <= target;
            calibration_error <= cal_err;
            prev_pos          <= position;
            state             <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/throttle_pid_controller_top.sv */
// Throttle PID controller. Each item carries a throttle and a pedal sample and yields one
// result: the drive value, scaled positions and a calibration flag. An item occupies the
// back part from the step that takes it, through 17 steps of the restoring divider for
// the throttle scaling, a step to fix the quotient sign, four passes through one shared
// 33x19 multiplier, an integral step and an output step, to the result being held until
// it is taken; only then is the next item taken. A two-item queue sits in front, so up to
// two items are taken while a result waits.
module throttle_pid_controller_top #(
  parameter int OUT_MIN = tpc_pkg::OUT_MIN_DEF,
  parameter int OUT_MAX = tpc_pkg::OUT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  tps_sample,
  input  logic [7:0]  pedal_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  drive_value,
  output logic [16:0] throttle_position,
  output logic [10:0] target_position,
  output logic        calibration_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tpc_pkg::*;

  logic [7:0]  tps_min, tps_max;
  logic [31:0] kp_gain, ki_gain, kd_gain;
  logic        reverse_direction, prop_on_measurement;
  logic        job_valid, job_take;
  tpc_job_t    job;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tps_min             <= 8'd0;
      tps_max             <= 8'd255;
      kp_gain             <= 32'd134217728;
      ki_gain             <= 32'd2;
      kd_gain             <= 32'd201326592;
      reverse_direction   <= 1'b0;
      prop_on_measurement <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TPS_MIN:   tps_min <= cfg_data[7:0];
        REG_TPS_MAX:   tps_max <= cfg_data[7:0];
        REG_KP:        kp_gain <= cfg_data;
        REG_KI:        ki_gain <= cfg_data;
        REG_KD:        kd_gain <= cfg_data;
        REG_REVERSE:   reverse_direction <= cfg_data[0];
        REG_PROP_MEAS: prop_on_measurement <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tpc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .tps_sample, .pedal_sample,
    .tps_min, .tps_max, .job_valid, .job_take, .job
  );

  tpc_back #(.OUT_MIN(OUT_MIN), .OUT_MAX(OUT_MAX)) u_back (
    .clk, .rst, .job_valid, .job_take, .job,
    .kp_gain, .ki_gain, .kd_gain, .reverse_direction, .prop_on_measurement,
    .out_valid, .out_stall, .drive_value, .throttle_position, .target_position,
    .calibration_error
  );

endmodule

/* sv/tpc_checker.sv */
module tpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  drive_value,
  input logic [16:0] throttle_position,
  input logic        calibration_error
);

  // A held result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_value))
    else $error("result changed while stalled");

  // A calibration fault always reports position zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && calibration_error |-> throttle_position == 17'd0)
    else $error("position nonzero under calibration fault");

  // No result right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // A stalled input item stays offered.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input item withdrawn while stalled");

endmodule

bind throttle_pid_controller_top tpc_checker u_tpc_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .drive_value, .throttle_position, .calibration_error
);

/* dv/tb_throttle_pid_controller_top.sv */
module tb_throttle_pid_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpc_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_ITEMS = 650;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  tps_sample;
  logic [7:0]  pedal_sample;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  drive_value;
  logic [16:0] throttle_position;
  logic [10:0] target_position;
  logic        calibration_error;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  throttle_pid_controller_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .tps_sample(tps_sample), .pedal_sample(pedal_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_value(drive_value), .throttle_position(throttle_position),
    .target_position(target_position), .calibration_error(calibration_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [7:0]  drive;
    logic [16:0] position;
    logic [10:0] target;
    logic        cal_err;
  } drive_result_t;

  // One row of the directed table: check marks a row with a result typed in.
  typedef struct {
    logic [7:0]    tps;
    logic [7:0]    pedal;
    bit            check;
    drive_result_t known;
  } directed_row_t;

  // Controller copy of the configuration and loop state.
  logic [7:0]         m_tps_min, m_tps_max;
  logic signed [31:0] m_kp, m_ki, m_kd;
  logic               m_reverse, m_prop_meas;
  longint             m_integral, m_prev_pos;
  bit                 m_primed;

  drive_result_t expected_drives[$];
  int  mismatches;
  int  quiet_cycles;
  bit  hold_receiver;
  bit  sender_busy_free;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp_q24(longint v);
    longint lo, hi;
    lo = longint'(OUT_MIN_DEF) <<< ONE_Q24_SHIFT;
    hi = longint'(OUT_MAX_DEF) <<< ONE_Q24_SHIFT;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Scale the samples and run one PID step on the model state.
  function automatic drive_result_t pid_step(logic [7:0] tps, logic [7:0] pedal);
    drive_result_t r;
    longint pos, tgt, kp, ki, kd, err, dpos, acc;
    kp = m_kp;
    ki = m_ki;
    kd = m_kd;
    r.cal_err = (m_tps_max == m_tps_min);
    if (r.cal_err) pos = 0;
    else pos = ((longint'(tps) - longint'(m_tps_min)) * FULL_SCALE) /
               (longint'(m_tps_max) - longint'(m_tps_min));
    tgt = ((longint'(pedal) - PEDAL_LOW) * FULL_SCALE) / PEDAL_SPAN;
    if (m_reverse) begin
      kp = -kp;
      ki = -ki;
      kd = -kd;
    end
    if (!m_primed) begin
      m_prev_pos = pos;
      m_primed = 1'b1;
    end
    err = tgt - pos;
    dpos = pos - m_prev_pos;
    acc = m_integral + ki * err;
    if (m_prop_meas) acc -= kp * dpos;
    m_integral = clamp_q24(acc);
    acc = m_prop_meas ? 0 : kp * err;
    acc += m_integral - kd * dpos;
    acc = clamp_q24(acc);
    m_prev_pos = pos;
    r.drive = 8'(acc >>> ONE_Q24_SHIFT);
    r.position = 17'(pos);
    r.target = 11'(tgt);
    return r;
  endfunction

  function automatic void note_config(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_TPS_MIN:   m_tps_min = data[7:0];
      REG_TPS_MAX:   m_tps_max = data[7:0];
      REG_KP:        m_kp = data;
      REG_KI:        m_ki = data;
      REG_KD:        m_kd = data;
      REG_REVERSE:   m_reverse = data[0];
      REG_PROP_MEAS: m_prop_meas = data[0];
      default: ;
    endcase
  endfunction

  // Write one register, holding the write until it is taken.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    note_config(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every expected result has come, then let the block settle.
  task automatic drain();
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Offer one item; the expectation is queued when the block takes it.
  task automatic send_item(logic [7:0] tps, logic [7:0] pedal, bit check,
                           drive_result_t known);
    drive_result_t r;
    if (!sender_busy_free) begin
      while ($urandom_range(99) < 25) @(negedge clk);
    end
    tps_sample = tps;
    pedal_sample = pedal;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = pid_step(tps, pedal);
    if (check && r != known) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row mismatch: table %h model %h", known, r);
    end
    expected_drives.push_back(r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Receiver: random stalls, with a calm stretch and one long hold-off.
  initial begin
    int cyc;
    out_stall = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_receiver) out_stall <= 1'b1;
      else if (cyc > 3000 && cyc < 5000) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 25);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    drive_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{drive_value, throttle_position, target_position, calibration_error};
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with none expected: %h", got);
      end else begin
        want = expected_drives.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: drive %0d/%0d pos %h/%h target %h/%h cal %b/%b",
                     want.drive, got.drive, want.position, got.position,
                     want.target, got.target, want.cal_err, got.cal_err);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_throttle_pid_controller_top: errors");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t rows[$];
    drive_result_t none;
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    tps_sample = '0;
    pedal_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    hold_receiver = 1'b0;
    sender_busy_free = 1'b0;
    m_tps_min = 8'd0;
    m_tps_max = 8'd255;
    m_kp = 32'sd134217728;
    m_ki = 32'sd2;
    m_kd = 32'sd201326592;
    m_reverse = 1'b0;
    m_prop_meas = 1'b0;
    m_integral = 0;
    m_prev_pos = 0;
    m_primed = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // After reset: first item primes, extremes of both samples.
    rows.push_back('{8'd0, 8'd18, 1'b1, '{8'd0, 17'd0, 11'd0, 1'b0}});
    rows.push_back('{8'd255, 8'd255, 1'b0, none});
    rows.push_back('{8'd0, 8'd0, 1'b0, none});
    rows.push_back('{8'd128, 8'd102, 1'b0, none});
    rows.push_back('{8'd255, 8'd0, 1'b0, none});
    rows.push_back('{8'd1, 8'd254, 1'b0, none});
    foreach (rows[i]) send_item(rows[i].tps, rows[i].pedal, rows[i].check, rows[i].known);
    drain();

    // Equal calibration forces a zero position and the error flag; the drop from
    // position one leaves the full derivative gain on the output.
    write_reg(REG_TPS_MIN, 32'hFFFF_FF50);
    write_reg(REG_TPS_MAX, 32'h0000_0050);
    send_item(8'd200, 8'd18, 1'b1, '{8'd12, 17'd0, 11'd0, 1'b1});
    send_item(8'd0, 8'd120, 1'b0, none);
    drain();

    // Inverted calibration, reverse action, proportional on measurement.
    write_reg(REG_TPS_MIN, 32'd255);
    write_reg(REG_TPS_MAX, 32'd0);
    write_reg(REG_KP, 32'h8000_0000);
    write_reg(REG_KI, 32'h7FFF_FFFF);
    write_reg(REG_KD, 32'h7FFF_FFFF);
    write_reg(REG_REVERSE, 32'hFFFF_FFFF);
    write_reg(REG_PROP_MEAS, 32'd1);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    send_item(8'd0, 8'd255, 1'b0, none);
    send_item(8'd255, 8'd0, 1'b0, none);
    send_item(8'd77, 8'd60, 1'b0, none);
    send_item(8'd200, 8'd30, 1'b0, none);
    drain();

    // Random phases, each with a fresh register setting.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_TPS_MIN, (ph % 4 == 0) ? 32'd0 : $urandom_range(80));
      write_reg(REG_TPS_MAX, (ph % 4 == 0) ? 32'd255 :
                (ph == 5 ? 32'd40 : 32'($urandom_range(255, 150))));
      write_reg(REG_KP, (ph == 3) ? 32'h7FFF_FFFF : 32'($signed($urandom_range(8000000))
                - 1000000) * (ph % 2 ? -1 : 1));
      write_reg(REG_KI, (ph == 6) ? 32'h8000_0000 : $urandom_range(400000));
      write_reg(REG_KD, (ph == 7) ? 32'h0 : $urandom());
      write_reg(REG_REVERSE, 32'(ph[0]));
      write_reg(REG_PROP_MEAS, 32'(ph[1]));
      sender_busy_free = (ph == 2);
      for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
        if (ph == 4 && n == 10) begin
          fork
            begin
              hold_receiver = 1'b1;
              repeat (300) @(posedge clk);
              hold_receiver = 1'b0;
            end
          join_none
        end
        send_item(8'($urandom()), 8'(($urandom_range(3) == 0) ? $urandom() :
                  $urandom_range(110, 10)), 1'b0, none);
      end
      drain();
    end

    if (mismatches == 0) $display("tb_throttle_pid_controller_top: clean");
    else $display("tb_throttle_pid_controller_top: errors");
    $finish;
  end

endmodule
